[rtl/pwls_pkg.sv]
// Shared types, constants and register map for the pulse-width LED serializer.
package pwls_pkg;

    localparam int COLOR_BITS_DEF   = 24;
    localparam int TICK_WIDTH_DEF   = 10;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam int COLOR_W  = 24;
    localparam int TIME_W   = 10;
    localparam int LEDS_W   = 8;
    localparam int BRIGHT_W = 2;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = 3;

    localparam logic [TIME_W-1:0] ONE_HIGH_RST  = TIME_W'(40);
    localparam logic [TIME_W-1:0] ONE_LOW_RST   = TIME_W'(22);
    localparam logic [TIME_W-1:0] ZERO_HIGH_RST = TIME_W'(20);
    localparam logic [TIME_W-1:0] ZERO_LOW_RST  = TIME_W'(42);
    localparam logic [LEDS_W-1:0] LEDS_RST      = LEDS_W'(20);

    typedef enum logic [IDX_W-1:0] {
        REG_BRIGHTNESS = 3'd0,
        REG_ONE_HIGH   = 3'd1,
        REG_ONE_LOW    = 3'd2,
        REG_ZERO_HIGH  = 3'd3,
        REG_ZERO_LOW   = 3'd4,
        REG_LEDS       = 3'd5
    } t_reg_idx;

    typedef enum logic [BRIGHT_W-1:0] {
        BR_FULL    = 2'd0,
        BR_3Q      = 2'd1,
        BR_HALF    = 2'd2,
        BR_QUARTER = 2'd3
    } t_bright;

    typedef struct packed {
        logic               operation;
        logic [COLOR_W-1:0] color;
    } t_in_item;

    typedef struct packed {
        logic line_out;
        logic busy_res;
        logic column_done;
    } t_out_item;

    typedef struct packed {
        logic               is_start;
        logic [COLOR_W-1:0] color;
    } t_cmd;

    typedef struct packed {
        t_bright             brightness;
        logic [TIME_W-1:0]   one_high;
        logic [TIME_W-1:0]   one_low;
        logic [TIME_W-1:0]   zero_high;
        logic [TIME_W-1:0]   zero_low;
        logic [LEDS_W-1:0]   leds;
    } t_cfg;

endpackage

[rtl/pulse_width_led_serializer_core.sv]
// Top level of the pulse-width LED serializer core.
// One item is one tick of line timing; the core takes one item per clock while
// full is low and returns exactly one result item for each, in order. An
// accepted item is classified and color-scaled on entry and held in a two-entry
// command queue. The serializer engine consumes it when the result queue is not
// full, updates its bit and phase counters and writes the line level, busy and
// column-done flags into a two-entry result queue, whose head is popped.
// full rises only when the result side stops popping and both queues fill.
// Registers are to be written over APB only while no items are in flight; the
// block itself does not enforce this.
module pulse_width_led_serializer_core #(
    parameter int COLOR_BITS         = pwls_pkg::COLOR_BITS_DEF,
    parameter int TICK_COUNTER_WIDTH = pwls_pkg::TICK_WIDTH_DEF,
    parameter int QUEUE_DEPTH        = pwls_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  pwls_pkg::t_in_item          i_in_item,
    output logic                        empty,
    input  logic                        pop,
    output pwls_pkg::t_out_item         o_out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pwls_pkg::ADDR_W-1:0] paddr,
    input  logic [pwls_pkg::DATA_W-1:0] pwdata,
    output logic [pwls_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int CMD_W = $bits(pwls_pkg::t_cmd);
    localparam int RES_W = $bits(pwls_pkg::t_out_item);

    pwls_pkg::t_cfg      cfg;
    pwls_pkg::t_cmd      cmd_in, cmd_out;
    pwls_pkg::t_out_item res_in;
    logic                cmd_push, cmd_full, cmd_empty, cmd_pop;
    logic                res_push, res_full;
    logic [CMD_W-1:0]    cmd_out_bits;
    logic [RES_W-1:0]    res_out_bits;

    assign cmd_out    = pwls_pkg::t_cmd'(cmd_out_bits);
    assign o_out_item = pwls_pkg::t_out_item'(res_out_bits);

    pwls_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pwls_front u_front (
        .i_push       (push),
        .i_item       (i_in_item),
        .o_full       (full),
        .i_brightness (cfg.brightness),
        .o_q_push     (cmd_push),
        .o_cmd        (cmd_in),
        .i_q_full     (cmd_full)
    );

    pwls_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out_bits),
        .o_empty (cmd_empty)
    );

    pwls_engine #(
        .COLOR_BITS         (COLOR_BITS),
        .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    pwls_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out_bits),
        .o_empty (empty)
    );

endmodule

[rtl/pwls_regs.sv]
// APB configuration register file.
module pwls_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pwls_pkg::ADDR_W-1:0] paddr,
    input  logic [pwls_pkg::DATA_W-1:0] pwdata,
    output logic [pwls_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output pwls_pkg::t_cfg              o_cfg
);

    pwls_pkg::t_cfg   r_cfg;
    pwls_pkg::t_reg_idx idx;
    logic             wr_en;

    assign idx    = pwls_pkg::t_reg_idx'(paddr[pwls_pkg::ADDR_W-1:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness <= pwls_pkg::BR_FULL;
            r_cfg.one_high   <= pwls_pkg::ONE_HIGH_RST;
            r_cfg.one_low    <= pwls_pkg::ONE_LOW_RST;
            r_cfg.zero_high  <= pwls_pkg::ZERO_HIGH_RST;
            r_cfg.zero_low   <= pwls_pkg::ZERO_LOW_RST;
            r_cfg.leds       <= pwls_pkg::LEDS_RST;
        end else if (wr_en) begin
            case (idx)
                pwls_pkg::REG_BRIGHTNESS: begin
                    r_cfg.brightness <= pwls_pkg::t_bright'(pwdata[pwls_pkg::BRIGHT_W-1:0]);
                end
                pwls_pkg::REG_ONE_HIGH:  r_cfg.one_high  <= pwdata[pwls_pkg::TIME_W-1:0];
                pwls_pkg::REG_ONE_LOW:   r_cfg.one_low   <= pwdata[pwls_pkg::TIME_W-1:0];
                pwls_pkg::REG_ZERO_HIGH: r_cfg.zero_high <= pwdata[pwls_pkg::TIME_W-1:0];
                pwls_pkg::REG_ZERO_LOW:  r_cfg.zero_low  <= pwdata[pwls_pkg::TIME_W-1:0];
                pwls_pkg::REG_LEDS:      r_cfg.leds      <= pwdata[pwls_pkg::LEDS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            pwls_pkg::REG_BRIGHTNESS: prdata = pwls_pkg::DATA_W'(r_cfg.brightness);
            pwls_pkg::REG_ONE_HIGH:   prdata = pwls_pkg::DATA_W'(r_cfg.one_high);
            pwls_pkg::REG_ONE_LOW:    prdata = pwls_pkg::DATA_W'(r_cfg.one_low);
            pwls_pkg::REG_ZERO_HIGH:  prdata = pwls_pkg::DATA_W'(r_cfg.zero_high);
            pwls_pkg::REG_ZERO_LOW:   prdata = pwls_pkg::DATA_W'(r_cfg.zero_low);
            pwls_pkg::REG_LEDS:       prdata = pwls_pkg::DATA_W'(r_cfg.leds);
            default:                  prdata = '0;
        endcase
    end

endmodule

[rtl/pwls_fifo.sv]
// Small register-based queue with simultaneous push and pop.
module pwls_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pwls_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/pwls_front.sv]
// Front end: accepts items, classifies starts and scales the start color.
module pwls_front (
    input  logic               i_push,
    input  pwls_pkg::t_in_item i_item,
    output logic               o_full,
    input  pwls_pkg::t_bright  i_brightness,
    output logic               o_q_push,
    output pwls_pkg::t_cmd     o_cmd,
    input  logic               i_q_full
);

    function automatic logic [7:0] scale_byte(input logic [7:0] b,
                                              input pwls_pkg::t_bright lvl);
        logic [7:0] r;
        case (lvl)
            pwls_pkg::BR_3Q:      r = b - (b >> 2);
            pwls_pkg::BR_HALF:    r = b >> 1;
            pwls_pkg::BR_QUARTER: r = b >> 2;
            default:              r = b;
        endcase
        return r;
    endfunction

    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;

    always_comb begin
        o_cmd.is_start = i_item.operation;
        o_cmd.color    = {scale_byte(i_item.color[23:16], i_brightness),
                          scale_byte(i_item.color[15:8],  i_brightness),
                          scale_byte(i_item.color[7:0],   i_brightness)};
    end

endmodule

[rtl/pwls_engine.sv]
// Back end: one-wire pulse-width serializer, one queued item per tick.
module pwls_engine #(
    parameter int COLOR_BITS         = pwls_pkg::COLOR_BITS_DEF,
    parameter int TICK_COUNTER_WIDTH = pwls_pkg::TICK_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pwls_pkg::t_cfg      i_cfg,
    input  logic                i_cmd_empty,
    input  pwls_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_res_full,
    output logic                o_res_push,
    output pwls_pkg::t_out_item o_res
);

    localparam int BPW = $clog2(COLOR_BITS);
    localparam int TW  = TICK_COUNTER_WIDTH;
    localparam logic [31:0] TICK_MAX = 32'((64'd1 << TW) - 64'd1);

    function automatic logic [TW-1:0] clamp_ticks(input logic [pwls_pkg::TIME_W-1:0] v);
        logic [31:0] vx;
        logic [31:0] r;
        vx = 32'(v);
        if (vx == '0) begin
            r = 32'd1;
        end else if (vx > TICK_MAX) begin
            r = TICK_MAX;
        end else begin
            r = vx;
        end
        return r[TW-1:0];
    endfunction

    logic [COLOR_BITS-1:0]      r_color, s_color;
    logic [BPW-1:0]             r_bp, s_bp, n_bp;
    logic                       r_low, s_low, n_low;
    logic [TW-1:0]              r_ticks, s_ticks, n_ticks, t_dec;
    logic [pwls_pkg::LEDS_W-1:0] r_leds, s_leds, n_leds, leds_dec;
    logic                       r_active, s_act, n_active;
    logic [31:0]                color_ext;
    logic                       fire;
    logic                       bit_hi;
    logic                       bit_next;

    assign fire       = !i_cmd_empty && !i_res_full;
    assign o_cmd_pop  = fire;
    assign o_res_push = fire;
    assign color_ext  = {8'd0, i_cmd.color};

    always_comb begin
        s_color = r_color;
        s_bp    = r_bp;
        s_low   = r_low;
        s_ticks = r_ticks;
        s_leds  = r_leds;
        s_act   = r_active;
        if (!r_active && i_cmd.is_start) begin
            s_color = color_ext[COLOR_BITS-1:0];
            s_bp    = BPW'(COLOR_BITS - 1);
            s_leds  = (i_cfg.leds == '0) ? pwls_pkg::LEDS_W'(1) : i_cfg.leds;
            s_act   = 1'b1;
            s_low   = 1'b0;
            s_ticks = clamp_ticks(s_color[COLOR_BITS-1] ? i_cfg.one_high : i_cfg.zero_high);
        end

        n_bp     = s_bp;
        n_low    = s_low;
        n_leds   = s_leds;
        n_active = s_act;
        o_res    = '0;
        t_dec    = (s_ticks != '0) ? s_ticks - 1'b1 : s_ticks;
        n_ticks  = t_dec;
        leds_dec = s_leds - 1'b1;
        bit_hi   = s_color[s_bp];
        bit_next = s_color[s_bp - 1'b1];

        if (s_act) begin
            o_res.line_out = !s_low;
            o_res.busy_res = 1'b1;
            if (t_dec == '0) begin
                if (!s_low) begin
                    n_low   = 1'b1;
                    n_ticks = clamp_ticks(bit_hi ? i_cfg.one_low : i_cfg.zero_low);
                end else if (s_bp != '0) begin
                    n_bp    = s_bp - 1'b1;
                    n_low   = 1'b0;
                    n_ticks = clamp_ticks(bit_next ? i_cfg.one_high : i_cfg.zero_high);
                end else begin
                    n_leds = leds_dec;
                    if (leds_dec != '0) begin
                        n_bp    = BPW'(COLOR_BITS - 1);
                        n_low   = 1'b0;
                        n_ticks = clamp_ticks(s_color[COLOR_BITS-1] ?
                                              i_cfg.one_high : i_cfg.zero_high);
                    end else begin
                        n_active          = 1'b0;
                        n_low             = 1'b0;
                        o_res.column_done = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color  <= '0;
            r_bp     <= '0;
            r_low    <= 1'b0;
            r_ticks  <= '0;
            r_leds   <= '0;
            r_active <= 1'b0;
        end else if (fire) begin
            r_color  <= s_color;
            r_bp     <= n_bp;
            r_low    <= n_low;
            r_ticks  <= n_ticks;
            r_leds   <= n_leds;
            r_active <= n_active;
        end
    end

`ifndef SYNTH
    a_active_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_ticks != '0) && (r_leds != '0))
        else $error("active column with empty tick or led count");

    a_done_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && o_res.column_done) |-> (o_res.busy_res && !o_res.line_out))
        else $error("column end item malformed");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && o_res.column_done) |=> !r_active)
        else $error("engine still active after column end");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_active && !i_cmd.is_start) |-> (o_res == '0))
        else $error("idle tick produced nonzero result");
`endif

endmodule

[tb/tb_pulse_width_led_serializer_core.sv]
// Self-checking testbench for the pulse-width LED serializer core.
`timescale 1ns / 1ps

module tb_pulse_width_led_serializer_core;

    localparam int          IDLE_LIMIT  = 4000;
    localparam int          DRAIN_TICKS = 6;
    localparam int          IN_W        = $bits(pwls_pkg::t_in_item);
    localparam logic [2:0]  REG_SPARE_6 = 3'd6;
    localparam logic [2:0]  REG_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {
        POP_ALWAYS,
        POP_RANDOM,
        POP_SPARSE,
        POP_HOLD
    } t_pop_mode;

    logic                          i_clk     = 1'b0;
    logic                          i_rst_n   = 1'b0;
    logic                          push      = 1'b0;
    logic                          full;
    pwls_pkg::t_in_item            i_in_item = '0;
    logic                          empty;
    logic                          pop       = 1'b0;
    pwls_pkg::t_out_item           o_out_item;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [pwls_pkg::ADDR_W-1:0]   paddr     = '0;
    logic [pwls_pkg::DATA_W-1:0]   pwdata    = '0;
    logic [pwls_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    // register shadow
    pwls_pkg::t_bright             cf_bright  = pwls_pkg::BR_FULL;
    logic [pwls_pkg::TIME_W-1:0]   cf_one_hi  = pwls_pkg::ONE_HIGH_RST;
    logic [pwls_pkg::TIME_W-1:0]   cf_one_lo  = pwls_pkg::ONE_LOW_RST;
    logic [pwls_pkg::TIME_W-1:0]   cf_zero_hi = pwls_pkg::ZERO_HIGH_RST;
    logic [pwls_pkg::TIME_W-1:0]   cf_zero_lo = pwls_pkg::ZERO_LOW_RST;
    logic [pwls_pkg::LEDS_W-1:0]   cf_leds    = pwls_pkg::LEDS_RST;

    // encoder state
    logic [pwls_pkg::COLOR_W-1:0]  enc_color  = '0;
    logic [4:0]                    enc_bitpos = '0;
    logic                          enc_low    = 1'b0;
    logic [pwls_pkg::TIME_W-1:0]   enc_left   = '0;
    logic [pwls_pkg::LEDS_W-1:0]   enc_leds   = '0;
    logic                          enc_active = 1'b0;

    pwls_pkg::t_out_item           pending_ticks[$];
    int                            mismatch_cnt = 0;
    int                            result_cnt   = 0;
    int                            idle_cycles  = 0;
    int                            burst_left   = 0;
    bit                            gaps_on      = 1'b1;
    t_pop_mode                     pop_mode     = POP_ALWAYS;
    int                            pop_run      = 0;
    int                            pop_phase    = 0;

    pulse_width_led_serializer_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] dim_byte(input logic [7:0] b,
                                            input pwls_pkg::t_bright lv);
        case (lv)
            pwls_pkg::BR_3Q:      return b - (b >> 2);
            pwls_pkg::BR_HALF:    return b >> 1;
            pwls_pkg::BR_QUARTER: return b >> 2;
            default:              return b;
        endcase
    endfunction

    function automatic logic [pwls_pkg::TIME_W-1:0] floor_one(
        input logic [pwls_pkg::TIME_W-1:0] v);
        return (v == '0) ? pwls_pkg::TIME_W'(1) : v;
    endfunction

    function automatic void load_phase(input logic low);
        logic b;
        b = enc_color[enc_bitpos];
        enc_low = low;
        if (low)
            enc_left = floor_one(b ? cf_one_lo : cf_zero_lo);
        else
            enc_left = floor_one(b ? cf_one_hi : cf_zero_hi);
    endfunction

    task automatic encode_tick(input pwls_pkg::t_in_item it, output pwls_pkg::t_out_item r);
        r = '0;
        if (!enc_active && it.operation) begin
            enc_color  = {dim_byte(it.color[23:16], cf_bright),
                          dim_byte(it.color[15:8], cf_bright),
                          dim_byte(it.color[7:0], cf_bright)};
            enc_bitpos = 5'(pwls_pkg::COLOR_W - 1);
            enc_leds   = (cf_leds != '0) ? cf_leds : pwls_pkg::LEDS_W'(1);
            enc_active = 1'b1;
            load_phase(1'b0);
        end
        if (enc_active) begin
            r.line_out = !enc_low;
            r.busy_res = 1'b1;
            if (enc_left != '0) enc_left = enc_left - 1'b1;
            if (enc_left == '0) begin
                if (!enc_low) begin
                    load_phase(1'b1);
                end else if (enc_bitpos != '0) begin
                    enc_bitpos = enc_bitpos - 1'b1;
                    load_phase(1'b0);
                end else begin
                    enc_leds = enc_leds - 1'b1;
                    if (enc_leds != '0) begin
                        enc_bitpos = 5'(pwls_pkg::COLOR_W - 1);
                        load_phase(1'b0);
                    end else begin
                        enc_active = 1'b0;
                        enc_low    = 1'b0;
                        r.column_done = 1'b1;
                    end
                end
            end
        end
    endtask

    function automatic void shadow_write(input logic [2:0] idx,
                                         input logic [pwls_pkg::DATA_W-1:0] d);
        case (idx)
            pwls_pkg::REG_BRIGHTNESS:
                cf_bright = pwls_pkg::t_bright'(d[pwls_pkg::BRIGHT_W-1:0]);
            pwls_pkg::REG_ONE_HIGH:  cf_one_hi  = d[pwls_pkg::TIME_W-1:0];
            pwls_pkg::REG_ONE_LOW:   cf_one_lo  = d[pwls_pkg::TIME_W-1:0];
            pwls_pkg::REG_ZERO_HIGH: cf_zero_hi = d[pwls_pkg::TIME_W-1:0];
            pwls_pkg::REG_ZERO_LOW:  cf_zero_lo = d[pwls_pkg::TIME_W-1:0];
            pwls_pkg::REG_LEDS:      cf_leds    = d[pwls_pkg::LEDS_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic want, input logic got);
        if (mismatch_cnt < 100)
            $display("ERROR result %0d: %s expected %0b got %0b", result_cnt, what, want, got);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin : result_check
        pwls_pkg::t_out_item want;
        if (i_rst_n) begin
            if (push && !full) begin
                encode_tick(i_in_item, want);
                pending_ticks.push_back(want);
            end
            if (pop && !empty) begin
                if (pending_ticks.size() == 0) begin
                    report_mismatch("unexpected item", 1'b0, 1'b1);
                end else begin
                    want = pending_ticks.pop_front();
                    if (o_out_item.line_out !== want.line_out)
                        report_mismatch("line_out", want.line_out, o_out_item.line_out);
                    if (o_out_item.busy_res !== want.busy_res)
                        report_mismatch("busy_res", want.busy_res, o_out_item.busy_res);
                    if (o_out_item.column_done !== want.column_done)
                        report_mismatch("column_done", want.column_done,
                                        o_out_item.column_done);
                end
                result_cnt++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (pop_run == 0) begin
            pop_mode = t_pop_mode'($urandom_range(0, 3));
            pop_run  = (pop_mode == POP_HOLD) ? $urandom_range(1, 20) : $urandom_range(10, 80);
            pop_phase = 0;
        end
        pop_run--;
        pop_phase++;
        case (pop_mode)
            POP_ALWAYS: pop <= 1'b1;
            POP_RANDOM: pop <= ($urandom_range(0, 3) != 0);
            POP_SPARSE: pop <= (pop_phase % 4 == 0);
            default:    pop <= 1'b0;
        endcase
    end

    function automatic logic [pwls_pkg::COLOR_W-1:0] pick_color();
        case ($urandom_range(0, 7))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return 24'hFF0000;
            3:       return 24'h00FF00;
            4:       return 24'h0000FF;
            default: return pwls_pkg::COLOR_W'($urandom);
        endcase
    endfunction

    task automatic send_tick(input logic op, input logic [pwls_pkg::COLOR_W-1:0] col);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
            if (gap != 0) begin
                push      <= 1'b0;
                i_in_item <= pwls_pkg::t_in_item'(IN_W'($urandom));
                repeat (gap) @(negedge i_clk);
            end
        end
        if (burst_left != 0) burst_left--;
        push      <= 1'b1;
        i_in_item <= '{operation: op, color: col};
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        push <= 1'b0;
        while (pending_ticks.size() != 0) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [pwls_pkg::DATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= pwls_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_write(idx, d);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic config_all(input pwls_pkg::t_bright br, input int oh, input int ol,
                              input int zh, input int zl, input int leds);
        hold_until_drained();
        repeat (DRAIN_TICKS) @(negedge i_clk);
        apb_write(pwls_pkg::REG_BRIGHTNESS, pwls_pkg::DATA_W'(br));
        apb_write(pwls_pkg::REG_ONE_HIGH, pwls_pkg::DATA_W'(oh));
        apb_write(pwls_pkg::REG_ONE_LOW, pwls_pkg::DATA_W'(ol));
        apb_write(pwls_pkg::REG_ZERO_HIGH, pwls_pkg::DATA_W'(zh));
        apb_write(pwls_pkg::REG_ZERO_LOW, pwls_pkg::DATA_W'(zl));
        apb_write(pwls_pkg::REG_LEDS, pwls_pkg::DATA_W'(leds));
    endtask

    // plain ticks until the column ends; the odd start while busy is ignored
    task automatic run_column(input logic [pwls_pkg::COLOR_W-1:0] col);
        send_tick(1'b1, col);
        while (enc_active)
            send_tick($urandom_range(0, 15) == 0, pick_color());
    endtask

    // reset timing on the first bits, then short timing to end the column
    task automatic test_default_column();
        repeat (4) send_tick(1'b0, pick_color());
        hold_until_drained();
        repeat (DRAIN_TICKS) @(negedge i_clk);
        apb_write(pwls_pkg::REG_LEDS, pwls_pkg::DATA_W'(1));
        send_tick(1'b1, 24'hA5C33C);
        repeat (100) send_tick(1'b0, pick_color());
        config_all(pwls_pkg::BR_FULL, 2, 1, 1, 1, 1);
        while (enc_active) send_tick(1'b0, pick_color());
    endtask

    task automatic test_brightness();
        for (int lv = 0; lv < 4; lv++) begin
            config_all(pwls_pkg::t_bright'(lv), 2, 1, 1, 1, 1);
            run_column(24'hFFFFFF);
            send_tick(1'b0, 24'hFFFFFF);
        end
    endtask

    task automatic test_zero_and_masked_regs();
        config_all(pwls_pkg::BR_3Q, 0, 0, 0, 0, 0);
        run_column(24'h5A0FF0);
        hold_until_drained();
        repeat (DRAIN_TICKS) @(negedge i_clk);
        apb_write(REG_SPARE_6, 32'hFFFF_FFFF);
        apb_write(REG_SPARE_7, 32'h0000_0003);
        apb_write(pwls_pkg::REG_ONE_HIGH, 32'hFFFF_FC02);
        apb_write(pwls_pkg::REG_LEDS, 32'hFFFF_FF01);
        apb_write(pwls_pkg::REG_BRIGHTNESS, 32'hFFFF_FFFE);
        run_column(24'hC0FFEE);
    endtask

    task automatic test_timing_extremes();
        config_all(pwls_pkg::BR_FULL, 30, 1, 1, 1, 1);
        run_column(24'h800001);
        config_all(pwls_pkg::BR_FULL, 1, 1, 1, 30, 1);
        run_column(24'h7FFFFF);
    endtask

    task automatic test_change_while_busy();
        config_all(pwls_pkg::BR_HALF, 3, 2, 1, 4, 1);
        send_tick(1'b1, 24'h3C96E1);
        repeat (30) send_tick(1'b0, pick_color());
        config_all(pwls_pkg::BR_FULL, 2, 5, 4, 1, 200);
        while (enc_active) send_tick(1'b0, pick_color());
    endtask

    task automatic test_random();
        logic op;
        for (int ph = 0; ph < 3; ph++) begin
            gaps_on = (ph != 1);
            config_all(pwls_pkg::t_bright'($urandom_range(0, 3)),
                       $urandom_range(0, 3), $urandom_range(0, 3),
                       $urandom_range(0, 3), $urandom_range(0, 3),
                       $urandom_range(0, 2));
            for (int n = 0; n < 40; n++) begin
                if (ph == 2 && n == 20) hold_until_drained();
                if (!enc_active)
                    op = ($urandom_range(0, 3) != 0);
                else
                    op = ($urandom_range(0, 15) == 0);
                send_tick(op, pick_color());
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_default_column();
        test_brightness();
        test_zero_and_masked_regs();
        test_timing_extremes();
        test_change_while_busy();
        test_random();
        hold_until_drained();
        repeat (DRAIN_TICKS) @(negedge i_clk);
        if (pending_ticks.size() != 0)
            report_mismatch("items left over", 1'b0, 1'b1);
        if (mismatch_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
